/* rtl/ookfm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ookfm_pkg
// Shared types, constants and the carrier table of the on-off keyed I/Q
// frame modulator.
// ----------------------------------------------------------------------------
package ookfm_pkg;

    // default frame geometry
    localparam int PREAMBLE_PAIRS_DEF = 128;
    localparam int CODE_BYTES_DEF     = 20;

    // carrier: one period spans CARRIER_PERIOD samples, peak amplitude 1842
    localparam int CARRIER_PERIOD = 40;
    localparam int PHASE_W        = $clog2(CARRIER_PERIOD);
    localparam int QUARTER_PERIOD = CARRIER_PERIOD / 4;
    localparam int SAMPLE_W       = 12;

    // input fields
    localparam int BYTE_INDEX_W = 5;
    localparam int BYTE_W       = 8;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_SAMPLES = 2'd2;

    localparam logic [CFG_W-1:0] BIT_SAMPLES_RST = 16'd4052;
    localparam logic [CFG_W-1:0] GAP_SAMPLES_RST = 16'd16211;
    localparam logic [CFG_W-1:0] PAD_SAMPLES_RST = 16'd32422;

    // opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // truncated amplitude * sin(2*pi*k/period)
    localparam logic signed [SAMPLE_W-1:0] SINE_TABLE [0:CARRIER_PERIOD-1] = '{
        12'sd0,     12'sd288,   12'sd569,   12'sd836,   12'sd1082,
        12'sd1302,  12'sd1490,  12'sd1641,  12'sd1751,  12'sd1819,
        12'sd1842,  12'sd1819,  12'sd1751,  12'sd1641,  12'sd1490,
        12'sd1302,  12'sd1082,  12'sd836,   12'sd569,   12'sd288,
        12'sd0,     -12'sd288,  -12'sd569,  -12'sd836,  -12'sd1082,
        -12'sd1302, -12'sd1490, -12'sd1641, -12'sd1751, -12'sd1819,
        -12'sd1842, -12'sd1819, -12'sd1751, -12'sd1641, -12'sd1490,
        -12'sd1302, -12'sd1082, -12'sd836,  -12'sd569,  -12'sd288
    };

    // sample in flight between the code store read and the output register
    typedef struct packed {
        logic [PHASE_W-1:0] phase_sin;
        logic [PHASE_W-1:0] phase_cos;
        logic               is_code;
        logic               pre_on;
        logic [2:0]         bit_sel;
        logic               frame_end;
    } t_s1;

endpackage
`default_nettype wire

/* rtl/ook_frame_iq_modulator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ook_frame_iq_modulator_top
// On-off keyed I/Q frame modulator: a code byte store loaded by transactions,
// a frame sequencer, and a carrier table lookup.
// ----------------------------------------------------------------------------
// Path: a sample transaction is registered in the stage register, then in the
//   output register; a load transaction produces no output.
// Throughput: one transaction per cycle while the output channel does not stall;
//   the code store has one registered read port, read for code-section samples.
// Reset: counters and phase go to zero at the preamble start, registers to
//   their defaults; the code store holds garbage until loaded.
// ----------------------------------------------------------------------------
module ook_frame_iq_modulator_top #(
    parameter int PREAMBLE_PAIRS = ookfm_pkg::PREAMBLE_PAIRS_DEF,
    parameter int CODE_BYTES     = ookfm_pkg::CODE_BYTES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [ookfm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ookfm_pkg::CFG_W-1:0]           i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_opcode,
    input  wire logic [ookfm_pkg::BYTE_INDEX_W-1:0]    i_byte_index,
    input  wire logic [ookfm_pkg::BYTE_W-1:0]          i_byte_value,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [ookfm_pkg::SAMPLE_W-1:0]      o_i_sample,
    output logic signed [ookfm_pkg::SAMPLE_W-1:0]      o_q_sample,
    output logic                                       o_frame_end
);
    import ookfm_pkg::*;

    localparam int PRE_BITS  = 2 * PREAMBLE_PAIRS;
    localparam int CODE_BITS = 8 * CODE_BYTES;
    localparam int MAX_BITS  = (PRE_BITS > CODE_BITS) ? PRE_BITS : CODE_BITS;
    localparam int BP_W      = $clog2(MAX_BITS + 1);
    localparam int ADDR_W    = (CODE_BYTES > 1) ? $clog2(CODE_BYTES) : 1;

    typedef enum logic [2:0] {
        SEC_PREAMBLE = 3'd0,
        SEC_GAP      = 3'd1,
        SEC_CODE1    = 3'd2,
        SEC_PAD      = 3'd3,
        SEC_CODE2    = 3'd4
    } t_section;

    // configuration registers
    logic [CFG_W-1:0] r_bit_samples, r_gap_samples, r_pad_samples;

    // sequencer state
    t_section           r_section, n_section;
    logic [BP_W-1:0]    r_bit_pos, n_bit_pos;
    logic [CFG_W-1:0]   r_sip, n_sip;
    logic [PHASE_W-1:0] r_phase, n_phase;

    // pipeline
    logic               r_s1_valid;
    t_s1                r_s1, n_s1;
    logic [BYTE_W-1:0]  r_rd_data;
    logic               r_out_valid;
    logic signed [SAMPLE_W-1:0] r_i_sample, r_q_sample;
    logic               r_frame_end;

    logic [BYTE_W-1:0]  code_mem [0:CODE_BYTES-1];

    // handshake
    logic in_acc, sample_acc, load_acc, s1_adv;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign sample_acc = in_acc && (i_opcode == OP_SAMPLE);
    assign load_acc   = in_acc && (i_opcode == OP_LOAD)
                        && ({1'b0, i_byte_index} < (BYTE_INDEX_W+1)'(CODE_BYTES));

    // sequencer next state
    t_section         sec_e;
    logic [BP_W-1:0]  bp_e, bp_inc, sec_bits;
    logic [CFG_W-1:0] sip_e, unit_len;
    logic [CFG_W:0]   sip_sum;
    logic             period_done;
    logic [PHASE_W:0] cos_idx;
    logic [ADDR_W-1:0] rd_addr;

    always_comb begin
        sec_e = r_section;
        bp_e  = r_bit_pos;
        sip_e = r_sip;
        // empty gap or pad is skipped, stray codes restart the frame
        case (r_section)
            SEC_GAP: begin
                if (r_gap_samples == '0) begin
                    sec_e = SEC_CODE1;
                    bp_e  = '0;
                    sip_e = '0;
                end
            end
            SEC_PAD: begin
                if (r_pad_samples == '0) begin
                    sec_e = SEC_CODE2;
                    bp_e  = '0;
                    sip_e = '0;
                end
            end
            SEC_PREAMBLE, SEC_CODE1, SEC_CODE2: begin
            end
            default: begin
                sec_e = SEC_PREAMBLE;
                bp_e  = '0;
                sip_e = '0;
            end
        endcase

        case (sec_e)
            SEC_GAP: unit_len = r_gap_samples;
            SEC_PAD: unit_len = r_pad_samples;
            default: unit_len = (r_bit_samples == '0) ? CFG_W'(1) : r_bit_samples;
        endcase

        case (sec_e)
            SEC_PREAMBLE:         sec_bits = BP_W'(PRE_BITS);
            SEC_CODE1, SEC_CODE2: sec_bits = BP_W'(CODE_BITS);
            default:              sec_bits = BP_W'(1);
        endcase

        // 17-bit sum: a wrap past 16 bits also ends the period
        sip_sum     = {1'b0, sip_e} + (CFG_W+1)'(1);
        period_done = sip_sum >= {1'b0, unit_len};
        bp_inc      = bp_e + BP_W'(1);

        n_section        = sec_e;
        n_bit_pos        = bp_e;
        n_sip            = sip_sum[CFG_W-1:0];
        n_s1.frame_end   = 1'b0;
        if (period_done) begin
            n_sip     = '0;
            n_bit_pos = bp_inc;
            if (bp_inc >= sec_bits) begin
                n_bit_pos = '0;
                case (sec_e)
                    SEC_PREAMBLE: n_section = SEC_GAP;
                    SEC_GAP:      n_section = SEC_CODE1;
                    SEC_CODE1:    n_section = SEC_PAD;
                    SEC_PAD:      n_section = SEC_CODE2;
                    SEC_CODE2: begin
                        n_section      = SEC_PREAMBLE;
                        n_s1.frame_end = 1'b1;
                    end
                    default:      n_section = SEC_PREAMBLE;
                endcase
            end
        end

        n_phase = (r_phase == PHASE_W'(CARRIER_PERIOD - 1)) ? '0 : r_phase + PHASE_W'(1);

        cos_idx = {1'b0, r_phase} + (PHASE_W+1)'(QUARTER_PERIOD);
        if (cos_idx >= (PHASE_W+1)'(CARRIER_PERIOD)) begin
            cos_idx = cos_idx - (PHASE_W+1)'(CARRIER_PERIOD);
        end

        n_s1.phase_sin = r_phase;
        n_s1.phase_cos = cos_idx[PHASE_W-1:0];
        n_s1.is_code   = (sec_e == SEC_CODE1) || (sec_e == SEC_CODE2);
        n_s1.pre_on    = (sec_e == SEC_PREAMBLE) && bp_e[0];
        n_s1.bit_sel   = bp_e[2:0];
        rd_addr        = bp_e[ADDR_W+2:3];
    end

    // code store: one write port for loads, one registered read for samples
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            code_mem[i_byte_index[ADDR_W-1:0]] <= i_byte_value;
        end
        if (sample_acc && n_s1.is_code) begin
            r_rd_data <= code_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_samples <= BIT_SAMPLES_RST;
            r_gap_samples <= GAP_SAMPLES_RST;
            r_pad_samples <= PAD_SAMPLES_RST;
            r_section     <= SEC_PREAMBLE;
            r_bit_pos     <= '0;
            r_sip         <= '0;
            r_phase       <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BIT_SAMPLES: r_bit_samples <= i_cfg_data;
                    CFG_GAP_SAMPLES: r_gap_samples <= i_cfg_data;
                    CFG_PAD_SAMPLES: r_pad_samples <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (sample_acc) begin
                r_section <= n_section;
                r_bit_pos <= n_bit_pos;
                r_sip     <= n_sip;
                r_phase   <= n_phase;
            end
            if (o_in_ready) begin
                r_s1_valid <= sample_acc;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    logic carrier_on;

    assign carrier_on = r_s1.is_code ? r_rd_data[3'd7 - r_s1.bit_sel] : r_s1.pre_on;

    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_i_sample  <= carrier_on ? SINE_TABLE[r_s1.phase_sin] : '0;
            r_q_sample  <= carrier_on ? SINE_TABLE[r_s1.phase_cos] : '0;
            r_frame_end <= r_s1.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_i_sample  = r_i_sample;
    assign o_q_sample  = r_q_sample;
    assign o_frame_end = r_frame_end;

endmodule
`default_nettype wire

/* sim/ook_frame_iq_modulator_top_tb.sv */
// ----------------------------------------------------------------------------
// ook_frame_iq_modulator_top_tb
// Self-checking bench for the on-off keyed I/Q frame modulator. A queue of
// load and sample transactions is pushed through the input channel while a
// local copy of the frame sequencer predicts every I/Q sample. Output
// samples are compared field by field in order. The frame geometry is
// reprogrammed between runs: a one-sample bit period, the largest lengths,
// and zero lengths.
// ----------------------------------------------------------------------------
module ook_frame_iq_modulator_top_tb;
    import ookfm_pkg::*;

    localparam int PREAMBLE_PAIRS = PREAMBLE_PAIRS_DEF;
    localparam int CODE_BYTES     = CODE_BYTES_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 250;
    localparam int MAX_CYCLES     = 200000;

    typedef enum logic [2:0] {
        FR_PREAMBLE, FR_GAP, FR_CODE_A, FR_PAD, FR_CODE_B
    } t_frame_sec;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} t_idle_mode;

    typedef struct packed {
        logic                    op;
        logic [BYTE_INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]       val;
    } t_mod_op;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_s;
        logic signed [SAMPLE_W-1:0] q_s;
        logic                       frame_end;
    } t_iq;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index  = '0;
    logic [CFG_W-1:0]           i_cfg_data   = '0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_ready;
    logic                       i_opcode     = 1'b0;
    logic [BYTE_INDEX_W-1:0]    i_byte_index = '0;
    logic [BYTE_W-1:0]          i_byte_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0] o_i_sample;
    logic signed [SAMPLE_W-1:0] o_q_sample;
    logic                       o_frame_end;

    ook_frame_iq_modulator_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_i_sample   (o_i_sample),
        .o_q_sample   (o_q_sample),
        .o_frame_end  (o_frame_end)
    );

    // local copy of the modulator state
    logic [BYTE_W-1:0] code_mem [0:CODE_BYTES-1];
    logic [CFG_W-1:0]  bit_len, gap_len, pad_len;
    logic [2:0]        frame_sec;
    int unsigned       carrier_phase, bit_pos, period_pos;

    // first quarter of the carrier, peak 1842
    logic signed [SAMPLE_W-1:0] quarter_amp [0:10] = '{
        12'sd0, 12'sd288, 12'sd569, 12'sd836, 12'sd1082, 12'sd1302,
        12'sd1490, 12'sd1641, 12'sd1751, 12'sd1819, 12'sd1842
    };

    t_mod_op     op_queue [$];
    t_iq         iq_due [$];
    t_mod_op     next_op;
    t_iq         want;
    t_idle_mode  tx_mode = IDLE_FULL;
    t_idle_mode  rx_mode = IDLE_FULL;
    logic        hold_req = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned n_cycles = 0;
    int unsigned n_checked = 0;
    int unsigned n_frame_ends = 0;
    int unsigned n_loads = 0;
    int unsigned n_fail = 0;

    function automatic logic signed [SAMPLE_W-1:0] wave(input int unsigned k);
        if (k <= QUARTER_PERIOD) return quarter_amp[k];
        if (k <= 2 * QUARTER_PERIOD) return quarter_amp[2 * QUARTER_PERIOD - k];
        if (k <= 3 * QUARTER_PERIOD) return -quarter_amp[k - 2 * QUARTER_PERIOD];
        return -quarter_amp[CARRIER_PERIOD - k];
    endfunction

    function automatic int unsigned span_len();
        case (frame_sec)
            FR_GAP:  return 32'(gap_len);
            FR_PAD:  return 32'(pad_len);
            default: return (bit_len == 0) ? 1 : 32'(bit_len);
        endcase
    endfunction

    function automatic t_iq modulate_next();
        t_iq         r;
        logic        on;
        int unsigned nbits;
        r = '0;
        if (frame_sec > FR_CODE_B) begin
            frame_sec  = FR_PREAMBLE;
            bit_pos    = 0;
            period_pos = 0;
        end
        // zero-length gap or pad is skipped entirely
        while ((frame_sec == FR_GAP || frame_sec == FR_PAD) && span_len() == 0) begin
            frame_sec  = frame_sec + 3'd1;
            bit_pos    = 0;
            period_pos = 0;
        end
        case (frame_sec)
            FR_PREAMBLE:          on = bit_pos[0];
            FR_CODE_A, FR_CODE_B: on = (bit_pos < 8 * CODE_BYTES) &&
                                       code_mem[bit_pos >> 3][7 - (bit_pos & 7)];
            default:              on = 1'b0;
        endcase
        if (on) begin
            r.i_s = wave(carrier_phase);
            r.q_s = wave((carrier_phase + QUARTER_PERIOD) % CARRIER_PERIOD);
        end
        carrier_phase = (carrier_phase + 1) % CARRIER_PERIOD;
        // a period already past a shortened length ends on this sample
        period_pos = (period_pos + 1) & 32'hFFFF;
        if (period_pos == 0 || period_pos >= span_len()) begin
            period_pos = 0;
            bit_pos++;
            case (frame_sec)
                FR_PREAMBLE:          nbits = 2 * PREAMBLE_PAIRS;
                FR_CODE_A, FR_CODE_B: nbits = 8 * CODE_BYTES;
                default:              nbits = 1;
            endcase
            if (bit_pos >= nbits) begin
                bit_pos = 0;
                if (frame_sec == FR_CODE_B) begin
                    frame_sec   = FR_PREAMBLE;
                    r.frame_end = 1'b1;
                end else begin
                    frame_sec = frame_sec + 3'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic int unsigned idle_draw(input t_idle_mode mode);
        case (mode)
            IDLE_FULL:  return $urandom_range(0, 18);
            IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
            default:    return 0;
        endcase
    endfunction

    function automatic void add_op(input logic op, input logic [BYTE_INDEX_W-1:0] idx,
                                   input logic [BYTE_W-1:0] val);
        t_mod_op m;
        m.op  = op;
        m.idx = idx;
        m.val = val;
        op_queue.push_back(m);
    endfunction

    function automatic void add_random(input int n, input int unsigned sample_pct);
        for (int k = 0; k < n; k++) begin
            add_op(($urandom_range(0, 99) < sample_pct) ? OP_SAMPLE : OP_LOAD,
                   5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BIT_SAMPLES: bit_len = val;
            CFG_GAP_SAMPLES: gap_len = val;
            CFG_PAD_SAMPLES: pad_len = val;
            default: ;
        endcase
    endtask

    // loads leave nothing behind to wait for, so allow the pipe to drain too
    task automatic wait_idle();
        while (op_queue.size() != 0 || i_in_valid || iq_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_opcode == OP_SAMPLE) begin
                    iq_due.push_back(modulate_next());
                end else begin
                    n_loads++;
                    if (i_byte_index < CODE_BYTES) code_mem[i_byte_index] = i_byte_value;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    i_in_valid <= 1'b0;
                end else if (op_queue.size() != 0) begin
                    next_op = op_queue.pop_front();
                    i_opcode     <= next_op.op;
                    i_byte_index <= next_op.idx;
                    i_byte_value <= next_op.val;
                    i_in_valid   <= 1'b1;
                    tx_wait = idle_draw(tx_mode);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (iq_due.size() == 0) begin
                    $error("sample transaction with nothing expected: i=%0d q=%0d end=%0b",
                           o_i_sample, o_q_sample, o_frame_end);
                    n_fail++;
                end else begin
                    want = iq_due.pop_front();
                    n_checked++;
                    if (want.frame_end) n_frame_ends++;
                    if (o_i_sample !== want.i_s) begin
                        $error("i_sample: expected %0d, got %0d", want.i_s, o_i_sample);
                        n_fail++;
                    end
                    if (o_q_sample !== want.q_s) begin
                        $error("q_sample: expected %0d, got %0d", want.q_s, o_q_sample);
                        n_fail++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, o_frame_end);
                        n_fail++;
                    end
                end
                rx_wait = idle_draw(rx_mode);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                rx_wait  = LONG_HOLD;
            end
            if (rx_wait != 0) begin
                rx_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        for (int k = 0; k < CODE_BYTES; k++) code_mem[k] = '0;
        bit_len       = BIT_SAMPLES_RST;
        gap_len       = GAP_SAMPLES_RST;
        pad_len       = PAD_SAMPLES_RST;
        frame_sec     = FR_PREAMBLE;
        carrier_phase = 0;
        bit_pos       = 0;
        period_pos    = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default geometry, full code store fill, out-of-range loads
        add_op(OP_SAMPLE, 5'd0, 8'h00);
        add_op(OP_SAMPLE, 5'h1F, 8'hFF);
        for (int k = 0; k < CODE_BYTES; k++) begin
            add_op(OP_LOAD, 5'(k), (k == 0) ? 8'h00 : (k == 1) ? 8'hFF :
                                   8'($urandom_range(0, 255)));
        end
        add_op(OP_LOAD, 5'h1F, 8'hFF);
        add_op(OP_LOAD, 5'(CODE_BYTES), 8'h00);
        add_op(OP_SAMPLE, 5'(CODE_BYTES), 8'h5A);
        wait_idle();

        // one-sample bit, gap and pad periods; receiver stalls long while the sender pushes
        write_reg(CFG_BIT_SAMPLES, 16'd1);
        write_reg(CFG_GAP_SAMPLES, 16'd1);
        write_reg(CFG_PAD_SAMPLES, 16'd1);
        write_reg(CFG_SPARE, 16'hFFFF);
        tx_mode  = IDLE_NONE;
        rx_mode  = IDLE_LIGHT;
        hold_req = 1'b1;
        add_random(620, 96);
        wait_idle();

        // largest lengths
        write_reg(CFG_BIT_SAMPLES, 16'hFFFF);
        write_reg(CFG_GAP_SAMPLES, 16'hFFFF);
        write_reg(CFG_PAD_SAMPLES, 16'hFFFF);
        tx_mode = IDLE_FULL;
        rx_mode = IDLE_FULL;
        add_random(40, 90);
        wait_idle();

        // zero bit period acts as one sample, zero gap and pad are skipped
        write_reg(CFG_BIT_SAMPLES, 16'd0);
        write_reg(CFG_GAP_SAMPLES, 16'd0);
        write_reg(CFG_PAD_SAMPLES, 16'd0);
        tx_mode = IDLE_LIGHT;
        rx_mode = IDLE_NONE;
        add_random(600, 97);
        wait_idle();

        $display("checked %0d I/Q samples with %0d frame ends, %0d code loads",
                 n_checked, n_frame_ends, n_loads);
        $display("geometries: reset default, one-sample bits, all-max, all-zero");
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
